// ----- hw/rtl/lsra_pkg.sv -----
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants of the linear scan register allocator
// Beat types, request codes, owner table entry and sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lsra_pkg;

  localparam int unsigned REG_COUNT_DEF = 32;
  localparam int unsigned POOL_W        = 6;
  localparam int unsigned POOL_EXT_W    = 7;
  localparam int unsigned POOL_RST      = 16;
  localparam int unsigned REG_W         = 5;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned AGE_W         = 16;

  typedef enum logic [1:0] {
    REQ_ANY  = 2'd0,
    REQ_PIN  = 2'd1,
    REQ_SKIP = 2'd2,
    REQ_RSVD = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]  interval_id;
    logic [POS_W-1:0] start_position;
    logic [POS_W-1:0] end_position;
    logic [1:0]       request_kind;
    logic [REG_W-1:0] wanted_register;
  } in_t;

  typedef struct packed {
    logic [REG_W-1:0] assigned_register;
    logic             was_skipped;
    logic             self_spilled;
    logic             victim_valid;
    logic [ID_W-1:0]  victim_id;
    logic [POS_W-1:0] spill_position;
    logic             logic_error;
  } out_t;

  // One owner table entry as stored in the RAM.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] end_pos;
    logic [AGE_W-1:0] age;
  } owner_t;

  // Running best candidate for eviction.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] end_pos;
    logic [AGE_W-1:0] age;
  } best_t;

  // Verdict of the compare unit on one entry.
  typedef struct packed {
    logic expired;
    logic live;
    logic better;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/linear_scan_register_allocator.sv -----
// ----------------------------------------------------------------------------
// linear_scan_register_allocator: one live interval per command
// Expires finished owners, serves any or pinned requests; skips bypass both.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                     Transfer
//  -------  ------------------------  ------------------------------------
//  input    start, busy, in_data      beat taken when start and not busy
//  result   out_valid, out_data       one-cycle strobe, cannot be stalled
//  config   cfg_we, cfg_wdata         pool_size written when cfg_we high
//
// A skip request answers in the cycle after it is taken and busy stays low.
// Any other request reads every owner table entry in turn through the
// single RAM read port (ST_SCAN), drains the read pipeline (ST_DRAIN),
// decides (ST_DECIDE) and then gives the result strobe.
// Reset is synchronous: it clears all owners, frees the reset pool of 16
// registers and zeroes the age counter. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_scan_register_allocator #(
  parameter int unsigned REGISTER_COUNT = lsra_pkg::REG_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lsra_pkg::in_t               in_data,
  output logic                             out_valid,
  output lsra_pkg::out_t                   out_data,
  input  wire logic                        cfg_we,
  input  wire logic [lsra_pkg::POOL_W-1:0] cfg_wdata
);

  import lsra_pkg::*;

  // Index width of the owner table, and width of the free map, which only
  // spans registers that can ever be in the pool.
  localparam int unsigned IW  = $clog2(REGISTER_COUNT);
  localparam int unsigned CW  = $clog2(REGISTER_COUNT + 1);
  localparam int unsigned FW  = (REGISTER_COUNT < 32) ? REGISTER_COUNT : 32;
  localparam int unsigned FIW = $clog2(FW);
  localparam int unsigned RST_POOL = (POOL_RST < FW) ? POOL_RST : FW;
  localparam logic [FW-1:0] RST_FREE = FW'((64'd1 << RST_POOL) - 64'd1);
  localparam logic [POOL_EXT_W-1:0] POOL_CAP = POOL_EXT_W'(FW);
  localparam logic [POOL_EXT_W-1:0] REG_LIM  = POOL_EXT_W'(REGISTER_COUNT);

  state_t                   st_r, st_nxt;
  in_t                      item_r, item_nxt;
  logic [POOL_W-1:0]        pool_r, pool_nxt;
  logic [REGISTER_COUNT-1:0] held_r, held_nxt;
  logic [FW-1:0]            free_r, free_nxt;
  logic [AGE_W-1:0]         ctr_r, ctr_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     pv_r, pv_nxt;
  logic [IW-1:0]            pidx_r, pidx_nxt;
  // Scan results: lowest free pool register, eviction candidate, and the
  // owner of the pinned register as it stands after expiry.
  logic                     ff_found_r, ff_found_nxt;
  logic [IW-1:0]            ff_idx_r, ff_idx_nxt;
  best_t                    best_r, best_nxt;
  logic [IW-1:0]            best_idx_r, best_idx_nxt;
  logic [ID_W-1:0]          best_id_r, best_id_nxt;
  logic                     w_held_r, w_held_nxt;
  logic [POS_W-1:0]         w_end_r, w_end_nxt;
  logic [ID_W-1:0]          w_id_r, w_id_nxt;
  logic                     ov_r, ov_nxt;
  out_t                     od_r, od_nxt;

  logic [POOL_EXT_W-1:0]    pool_eff;
  logic [POOL_EXT_W-1:0]    want_ext;
  logic [POOL_EXT_W-1:0]    pidx_ext;
  logic                     in_pool;
  logic [$bits(owner_t)-1:0] rd_raw;
  owner_t                   rd_ent;
  owner_t                   wr_ent;
  cmp_res_t                 cres;
  logic                     take;
  logic [IW-1:0]            tgt;

  assign pool_eff = (POOL_EXT_W'(pool_r) > POOL_CAP) ? POOL_CAP : POOL_EXT_W'(pool_r);
  assign want_ext = POOL_EXT_W'(item_r.wanted_register);
  assign pidx_ext = POOL_EXT_W'(pidx_r);
  assign in_pool  = pidx_ext < pool_eff;
  assign rd_ent   = owner_t'(rd_raw);
  assign busy     = (st_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign wr_ent.id      = item_r.interval_id;
  assign wr_ent.end_pos = item_r.end_position;
  assign wr_ent.age     = ctr_r;

  lsra_ram #(
    .WIDTH ($bits(owner_t)),
    .DEPTH (REGISTER_COUNT)
  ) u_owner_ram (
    .clk   (clk),
    .we    (take),
    .waddr (tgt),
    .wdata (wr_ent),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rd_raw)
  );

  lsra_cmp u_cmp (
    .held      (held_r[pidx_r]),
    .entry     (rd_ent),
    .start_pos (item_r.start_position),
    .best      (best_r),
    .res       (cres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      pool_r <= POOL_W'(POOL_RST);
      held_r <= '0;
      free_r <= RST_FREE;
      ctr_r  <= '0;
      pv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pool_r <= pool_nxt;
      held_r <= held_nxt;
      free_r <= free_nxt;
      ctr_r  <= ctr_nxt;
      pv_r   <= pv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    pidx_r     <= pidx_nxt;
    ff_found_r <= ff_found_nxt;
    ff_idx_r   <= ff_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    best_id_r  <= best_id_nxt;
    w_held_r   <= w_held_nxt;
    w_end_r    <= w_end_nxt;
    w_id_r     <= w_id_nxt;
    od_r       <= od_nxt;
  end

  always_comb begin
    st_nxt       = st_r;
    item_nxt     = item_r;
    pool_nxt     = cfg_we ? cfg_wdata : pool_r;
    held_nxt     = held_r;
    free_nxt     = free_r;
    ctr_nxt      = ctr_r;
    cnt_nxt      = cnt_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    ff_found_nxt = ff_found_r;
    ff_idx_nxt   = ff_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    best_id_nxt  = best_id_r;
    w_held_nxt   = w_held_r;
    w_end_nxt    = w_end_r;
    w_id_nxt     = w_id_r;
    ov_nxt       = 1'b0;
    od_nxt       = '0;
    take         = 1'b0;
    tgt          = '0;

    // Entry read in the previous cycle: expire it and rank it.
    if (pv_r) begin
      if (cres.expired) begin
        held_nxt[pidx_r] = 1'b0;
        if (in_pool) begin
          free_nxt[pidx_r[FIW-1:0]] = 1'b1;
        end
      end
      if (in_pool && !ff_found_r && (free_r[pidx_r[FIW-1:0]] || cres.expired)) begin
        ff_found_nxt = 1'b1;
        ff_idx_nxt   = pidx_r;
      end
      if (in_pool && cres.better) begin
        best_nxt.found   = 1'b1;
        best_nxt.end_pos = rd_ent.end_pos;
        best_nxt.age     = rd_ent.age;
        best_idx_nxt     = pidx_r;
        best_id_nxt      = rd_ent.id;
      end
      if (pidx_ext == want_ext) begin
        w_held_nxt = cres.live;
        w_end_nxt  = rd_ent.end_pos;
        w_id_nxt   = rd_ent.id;
      end
    end

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.request_kind == REQ_SKIP || in_data.request_kind == REQ_RSVD) begin
            ov_nxt             = 1'b1;
            od_nxt.was_skipped = 1'b1;
          end else begin
            item_nxt     = in_data;
            cnt_nxt      = '0;
            ff_found_nxt = 1'b0;
            best_nxt     = '0;
            w_held_nxt   = 1'b0;
            st_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pv_nxt   = 1'b1;
        pidx_nxt = cnt_r[IW-1:0];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(REGISTER_COUNT - 1)) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        st_nxt = ST_IDLE;
        ov_nxt = 1'b1;
        if (item_r.request_kind == REQ_PIN) begin
          od_nxt.assigned_register = item_r.wanted_register;
          tgt = IW'(item_r.wanted_register);
          if (want_ext >= REG_LIM) begin
            od_nxt.logic_error = 1'b1;
          end else if (w_held_r) begin
            if (w_end_r == item_r.start_position) begin
              // Equal end: the register changes hands without a spill.
              take = 1'b1;
            end else begin
              od_nxt.self_spilled   = 1'b1;
              od_nxt.victim_valid   = 1'b1;
              od_nxt.victim_id      = w_id_r;
              od_nxt.spill_position = item_r.start_position;
              take = (item_r.end_position > w_end_r);
            end
          end else if (want_ext < pool_eff) begin
            if (free_r[item_r.wanted_register[FIW-1:0]]) begin
              take = 1'b1;
              free_nxt[item_r.wanted_register[FIW-1:0]] = 1'b0;
            end else begin
              od_nxt.logic_error = 1'b1;
            end
          end else begin
            take = 1'b1;
          end
        end else if (ff_found_r) begin
          tgt  = ff_idx_r;
          take = 1'b1;
          free_nxt[ff_idx_r[FIW-1:0]] = 1'b0;
          od_nxt.assigned_register = REG_W'(ff_idx_r);
        end else if (best_r.found) begin
          // Pool is full: spill against the longest-lived pool owner.
          tgt  = best_idx_r;
          take = (item_r.end_position > best_r.end_pos);
          od_nxt.assigned_register = REG_W'(best_idx_r);
          od_nxt.self_spilled      = 1'b1;
          od_nxt.victim_valid      = 1'b1;
          od_nxt.victim_id         = best_id_r;
          od_nxt.spill_position    = item_r.start_position;
        end else begin
          od_nxt.logic_error = 1'b1;
        end
        if (take) begin
          held_nxt[tgt] = 1'b1;
          ctr_nxt       = ctr_r + 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_decide_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DECIDE |=> st_r == ST_IDLE && out_valid)
    else $error("decision cycle did not produce a result beat");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == ST_DECIDE) || $past(start && !busy))
    else $error("result beat without a decision or skip command");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SCAN |-> cnt_r < CW'(REGISTER_COUNT))
    else $error("scan index ran past the owner table");

  a_drain_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DRAIN |-> pv_r && pidx_r == IW'(REGISTER_COUNT - 1))
    else $error("drain cycle without the last table entry in flight");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lsra_ram.sv -----
// ----------------------------------------------------------------------------
// lsra_ram: generic single write, single read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module lsra_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lsra_cmp.sv -----
// ----------------------------------------------------------------------------
// lsra_cmp: shared compare unit of the allocator
// Judges one owner entry: expiry against the new start and eviction rank.
// ----------------------------------------------------------------------------
`default_nettype none

module lsra_cmp (
  input  wire logic                      held,
  input  wire lsra_pkg::owner_t          entry,
  input  wire logic [lsra_pkg::POS_W-1:0] start_pos,
  input  wire lsra_pkg::best_t           best,
  output lsra_pkg::cmp_res_t             res
);

  import lsra_pkg::*;

  logic [AGE_W-1:0] age_diff;

  always_comb begin
    age_diff    = entry.age - best.age;
    res.expired = held && (entry.end_pos < start_pos);
    res.live    = held && !res.expired;
    // Later end wins; on equal ends the younger owner wins, with wrapping ages.
    res.better  = res.live && (!best.found || (entry.end_pos > best.end_pos) ||
                  ((entry.end_pos == best.end_pos) && (age_diff != '0) &&
                   !age_diff[AGE_W-1]));
  end

endmodule

`default_nettype wire
